### rtl/slrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slrg_pkg;

  localparam int unsigned VALUE_W  = 30;
  localparam int unsigned POS_W    = 6;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]   pos_t;

  localparam value_t MODULUS       = 30'd1000000000;
  localparam value_t SEED_RESET    = 30'd456;
  localparam pos_t   TABLE_LEN     = 6'd55;
  localparam pos_t   FILL_STRIDE   = 6'd21;
  // position written by the last step of the scattered fill, (21*54) % 55
  localparam pos_t   FILL_LAST_POS = 6'd34;
  localparam pos_t   MIX_LAG       = 6'd30;
  localparam pos_t   BACK_INIT     = 6'd31;
  localparam int unsigned MIX_PASSES = 4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FILL_INIT,
    OP_FILL_STEP,
    OP_MIX_RD,
    OP_MIX_WR,
    OP_DRAW_RD,
    OP_DRAW_WR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic mix_last;
  } status_t;

  // (a - b) mod 1e9 for a, b already reduced
  function automatic value_t sub_mod(value_t a, value_t b);
    logic [VALUE_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[VALUE_W]) begin
      sub_mod = d[VALUE_W-1:0] + MODULUS;
    end else begin
      sub_mod = d[VALUE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/slrg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface slrg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface slrg_rsp_if;
  logic             valid;
  logic             ready;
  slrg_pkg::value_t value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface slrg_cfg_if;
  logic             valid;
  logic             ready;
  slrg_pkg::value_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/slrg_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module slrg_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire slrg_pkg::cmd_t   cmd_i,
  output slrg_pkg::status_t     sts_o,
  input  wire logic             seed_we_i,
  input  wire slrg_pkg::value_t seed_i,
  output slrg_pkg::value_t      value_o
);
  import slrg_pkg::*;

  value_t mem_q [TABLE_LEN];
  value_t rd_a_q, rd_b_q;

  value_t seed_q;
  value_t cur_q, nxt_q, value_q;
  pos_t   fill_pos_q, mix_i_q, front_q, back_q;

  value_t seed_mod, diff, wdata;
  pos_t   waddr, raddr_a, raddr_b;
  pos_t   front_adv, back_adv, mix_other, fill_pos_nxt;
  logic   we, re;
  logic [POS_W:0] lag_sum, stride_sum;

  function automatic pos_t advance(pos_t p);
    advance = (p >= TABLE_LEN) ? 6'd1 : p + 6'd1;
  endfunction

  // position 1..55 to memory row
  function automatic pos_t slot(pos_t p);
    slot = (p >= 6'd1 && p <= TABLE_LEN) ? p - 6'd1 : 6'd0;
  endfunction

  assign seed_mod  = (seed_q >= MODULUS) ? seed_q - MODULUS : seed_q;
  assign diff      = sub_mod(rd_a_q, rd_b_q);
  assign front_adv = advance(front_q);
  assign back_adv  = advance(back_q);

  assign lag_sum    = {1'b0, mix_i_q} + {1'b0, MIX_LAG};
  assign mix_other  = (lag_sum >= {1'b0, TABLE_LEN}) ? POS_W'(lag_sum - {1'b0, TABLE_LEN})
                                                     : lag_sum[POS_W-1:0];
  assign stride_sum   = {1'b0, fill_pos_q} + {1'b0, FILL_STRIDE};
  assign fill_pos_nxt = (stride_sum >= {1'b0, TABLE_LEN})
                        ? POS_W'(stride_sum - {1'b0, TABLE_LEN}) : stride_sum[POS_W-1:0];

  always_comb begin
    we      = 1'b0;
    re      = 1'b0;
    waddr   = '0;
    wdata   = diff;
    raddr_a = '0;
    raddr_b = '0;
    case (cmd_i.op)
      OP_FILL_INIT: begin
        we    = 1'b1;
        waddr = TABLE_LEN - 6'd1;
        wdata = seed_mod;
      end
      OP_FILL_STEP: begin
        we    = 1'b1;
        waddr = fill_pos_q - 6'd1;
        wdata = nxt_q;
      end
      OP_MIX_RD: begin
        re      = 1'b1;
        raddr_a = mix_i_q - 6'd1;
        raddr_b = mix_other;
      end
      OP_MIX_WR: begin
        we    = 1'b1;
        waddr = mix_i_q - 6'd1;
      end
      OP_DRAW_RD: begin
        re      = 1'b1;
        raddr_a = slot(front_adv);
        raddr_b = slot(back_adv);
      end
      OP_DRAW_WR: begin
        we    = 1'b1;
        waddr = slot(front_q);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // lag table, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_a_q <= mem_q[raddr_a];
      rd_b_q <= mem_q[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= SEED_RESET;
      front_q <= '0;
      back_q  <= BACK_INIT;
      mix_i_q <= 6'd1;
    end else begin
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
      case (cmd_i.op)
        OP_FILL_INIT: begin
          front_q <= '0;
          back_q  <= BACK_INIT;
          mix_i_q <= 6'd1;
        end
        OP_MIX_WR: begin
          mix_i_q <= (mix_i_q == TABLE_LEN) ? 6'd1 : mix_i_q + 6'd1;
        end
        OP_DRAW_RD: begin
          front_q <= front_adv;
          back_q  <= back_adv;
        end
        default: begin
          front_q <= front_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_FILL_INIT: begin
        cur_q      <= seed_mod;
        nxt_q      <= 30'd1;
        fill_pos_q <= FILL_STRIDE;
      end
      OP_FILL_STEP: begin
        nxt_q      <= sub_mod(cur_q, nxt_q);
        cur_q      <= nxt_q;
        fill_pos_q <= fill_pos_nxt;
      end
      OP_DRAW_WR: begin
        value_q <= diff;
      end
      default: begin
        cur_q <= cur_q;
      end
    endcase
  end

  assign sts_o.fill_last = (fill_pos_q == FILL_LAST_POS);
  assign sts_o.mix_last  = (mix_i_q == TABLE_LEN);
  assign value_o         = value_q;

endmodule

`default_nettype wire

### rtl/slrg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module slrg_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire logic              req_restart_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output slrg_pkg::cmd_t         cmd_o,
  input  wire slrg_pkg::status_t sts_i
);
  import slrg_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FILL    = 3'd1;
  localparam logic [2:0] S_MIX_RD  = 3'd2;
  localparam logic [2:0] S_MIX_WR  = 3'd3;
  localparam logic [2:0] S_DRAW_RD = 3'd4;
  localparam logic [2:0] S_DRAW_WR = 3'd5;

  localparam logic [1:0] LAST_PASS = 2'(MIX_PASSES - 1);

  logic [2:0] state_q, state_d;
  logic [1:0] pass_q, pass_d;
  logic       seeded_q, seeded_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    seeded_d    = seeded_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    cmd_o.op    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (!seeded_q || req_restart_i) begin
            cmd_o.op = OP_FILL_INIT;
            seeded_d = 1'b1;
            state_d  = S_FILL;
          end else begin
            cmd_o.op = OP_DRAW_RD;
            state_d  = S_DRAW_WR;
          end
        end
      end
      S_FILL: begin
        cmd_o.op = OP_FILL_STEP;
        if (sts_i.fill_last) begin
          pass_d  = '0;
          state_d = S_MIX_RD;
        end
      end
      S_MIX_RD: begin
        cmd_o.op = OP_MIX_RD;
        state_d  = S_MIX_WR;
      end
      S_MIX_WR: begin
        cmd_o.op = OP_MIX_WR;
        state_d  = S_MIX_RD;
        if (sts_i.mix_last) begin
          if (pass_q == LAST_PASS) begin
            state_d = S_DRAW_RD;
          end else begin
            pass_d = pass_q + 2'd1;
          end
        end
      end
      S_DRAW_RD: begin
        cmd_o.op = OP_DRAW_RD;
        state_d  = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        if (out_free) begin
          cmd_o.op    = OP_DRAW_WR;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/subtractive_lagged_random_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// subtractive lagged random generator, modulus one billion. each request item
// returns one value in 0..999999999 on rsp_o; the consumer divides by 1e9 for a
// fraction. the first request after reset, or any request with restart set,
// first reseeds the 55-entry lag table from the seed register (reduced mod 1e9):
// a scattered fill with stride 21, then four mixing passes with lag 31. a plain
// draw uses the single table memory: it first reads both lag entries into
// registered read ports, then writes the difference back and loads the output
// register once that register is free. a reseed comes before the draw: 1 + 54
// fill writes, then 4 x 55 entries, each read and then written. the next request
// is taken while a result still waits in the output register. the seed is written
// through cfg_i, always ready; write it only while idle, the block does not check

module subtractive_lagged_random_generator_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  slrg_req_if.sink    req_i,
  slrg_rsp_if.source  rsp_o,
  slrg_cfg_if.sink    cfg_i
);
  import slrg_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    seed_we;

  // seed register sits in the datapath, writes are always taken
  assign cfg_i.ready = 1'b1;
  assign seed_we     = cfg_i.valid;

  // sequencer: seeding passes and the two-step draw
  slrg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_restart_i (req_i.restart),
    .req_ready_o   (req_i.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  // lag table memory, pointers, fill registers and output register
  slrg_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .seed_we_i (seed_we),
    .seed_i    (cfg_i.data),
    .value_o   (rsp_o.value)
  );

endmodule

`default_nettype wire

### rtl/slrg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slrg_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             req_valid_i,
  input wire logic             req_ready_i,
  input wire logic             rsp_valid_i,
  input wire logic             rsp_ready_i,
  input wire slrg_pkg::value_t rsp_value_i
);
  import slrg_pkg::*;

  // a waiting result holds until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_value_i))
    else $error("result dropped or changed while stalled");

  // results stay within the modulus
  a_rsp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_value_i < MODULUS)
    else $error("result not below modulus");

  // one item in flight: no request taken in the cycle after one is accepted
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // a new result only appears after a busy cycle
  a_rsp_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("result without preceding work");

endmodule

bind subtractive_lagged_random_generator_unit slrg_checker u_slrg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_value_i (rsp_o.value)
);

`default_nettype wire

### bench/slrg_draw_checker.sv
`timescale 1ns / 1ps

module slrg_draw_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  slrg_req_if         req_mon,
  slrg_rsp_if         rsp_mon,
  slrg_cfg_if         cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  import slrg_pkg::*;

  localparam int unsigned LAG_DEPTH    = 55;
  localparam int unsigned SCATTER_STEP = 21;
  localparam int unsigned MIX_OFFSET   = 30;
  localparam int unsigned MIX_ROUNDS   = 4;
  localparam pos_t        FRONT_START  = 6'd0;
  localparam pos_t        BACK_START   = 6'd31;
  localparam int unsigned REPORT_LIMIT = 10;

  value_t      lag_mem [LAG_DEPTH];
  pos_t        front_pos;
  pos_t        back_pos;
  logic        table_live;
  value_t      seed_reg;
  value_t      due_values [$];
  int unsigned flaws;

  assign fail_count = flaws;

  // (a - b) mod 1e9, both operands already reduced
  function automatic value_t mod_diff(value_t a, value_t b);
    logic [31:0] d;
    d = 32'(a) + 32'(MODULUS) - 32'(b);
    if (d >= 32'(MODULUS)) begin
      d = d - 32'(MODULUS);
    end
    return d[VALUE_W-1:0];
  endfunction

  // positions run 1..55 and wrap back to 1
  function automatic pos_t step_pos(pos_t p);
    return (p >= pos_t'(LAG_DEPTH)) ? pos_t'(1) : p + pos_t'(1);
  endfunction

  function automatic void reseed_lag_table();
    value_t      cur;
    value_t      nxt;
    int unsigned spot;
    int unsigned partner;
    cur = (seed_reg >= MODULUS) ? seed_reg - MODULUS : seed_reg;
    nxt = value_t'(1);
    lag_mem[LAG_DEPTH-1] = cur;
    for (int unsigned i = 1; i < LAG_DEPTH; i++) begin
      spot = (SCATTER_STEP * i) % LAG_DEPTH;
      lag_mem[spot-1] = nxt;
      nxt = mod_diff(cur, nxt);
      cur = lag_mem[spot-1];
    end
    for (int unsigned r = 0; r < MIX_ROUNDS; r++) begin
      for (int unsigned i = 1; i <= LAG_DEPTH; i++) begin
        partner = 1 + ((i + MIX_OFFSET) % LAG_DEPTH);
        lag_mem[i-1] = mod_diff(lag_mem[i-1], lag_mem[partner-1]);
      end
    end
    front_pos  = FRONT_START;
    back_pos   = BACK_START;
    table_live = 1'b1;
  endfunction

  function automatic value_t draw_next_value(logic restart);
    value_t r;
    if (!table_live || restart) begin
      reseed_lag_table();
    end
    front_pos = step_pos(front_pos);
    back_pos  = step_pos(back_pos);
    r = mod_diff(lag_mem[front_pos-1], lag_mem[back_pos-1]);
    lag_mem[front_pos-1] = r;
    return r;
  endfunction

  function automatic void log_flaw(string what);
    flaws++;
    if (flaws <= REPORT_LIMIT) begin
      $display("%0t checker: %s", $realtime, what);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    value_t want;
    if (!rst_ni) begin
      seed_reg   = SEED_RESET;
      front_pos  = FRONT_START;
      back_pos   = BACK_START;
      table_live = 1'b0;
      flaws      = 0;
      due_values.delete();
      pending   <= 0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_values.size() == 0) begin
          log_flaw($sformatf("value %0d with no request outstanding", rsp_mon.value));
        end else begin
          want = due_values.pop_front();
          if (rsp_mon.value !== want) begin
            log_flaw($sformatf("value mismatch, expected %0d, got %0d", want, rsp_mon.value));
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        seed_reg = cfg_mon.data;
      end
      if (req_mon.valid && req_mon.ready) begin
        due_values.push_back(draw_next_value(req_mon.restart));
      end
      pending <= due_values.size();
    end
  end

endmodule

### bench/subtractive_lagged_random_generator_unit_tb.sv
`timescale 1ns / 1ps

module subtractive_lagged_random_generator_unit_tb;
  import slrg_pkg::*;

  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 200;
  // long enough for a reseed plus the longest stall on each side
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_GAP    = 8;
  localparam int unsigned END_SETTLE   = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        idle_on;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;

  slrg_req_if req_if ();
  slrg_rsp_if rsp_if ();
  slrg_cfg_if cfg_if ();

  subtractive_lagged_random_generator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // watches all three channels, predicts every draw and compares
  slrg_draw_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: cycles in a row where no channel moves an item
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // consumer back-pressure: while idling is on, ready drops in random bursts
  initial begin
    int unsigned hold;
    rsp_if.ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_on && rst_ni && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 15);
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // called at a clock edge; returns at the edge where the item is taken.
  // valid is left high so back-to-back items keep it up without a glitch
  task automatic push_request(input logic restart);
    req_if.valid   <= 1'b1;
    req_if.restart <= restart;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // stop sending and wait until every predicted value has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // seed writes happen only with the generator idle
  task automatic write_seed(input value_t seed_value);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= seed_value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // mostly plain draws, an occasional restart, random gaps between items while idling is on
  task automatic run_draws(input int unsigned count);
    repeat (count) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      push_request($urandom_range(0, 63) == 0);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    idle_on        = 1'b1;
    req_if.valid   = 1'b0;
    req_if.restart = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first request after reset seeds from the reset seed without restart
    push_request(1'b0);
    push_request(1'b0);
    push_request(1'b0);
    // explicit restart, then two restarts back to back
    push_request(1'b1);
    push_request(1'b0);
    push_request(1'b1);
    push_request(1'b1);

    // new seed is not used until the next restart
    write_seed(value_t'(0));
    push_request(1'b0);
    push_request(1'b1);
    push_request(1'b0);

    // largest in-range seed
    write_seed(MODULUS - value_t'(1));
    push_request(1'b1);
    push_request(1'b0);

    // seeds at and above the modulus fold back into range
    write_seed(MODULUS);
    push_request(1'b1);
    push_request(1'b0);
    write_seed('1);
    push_request(1'b1);
    push_request(1'b0);

    write_seed(value_t'(1));
    push_request(1'b1);

    // random phases: fresh seed each time, some phases with no idling at all,
    // and the last phase always at full rate
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      write_seed(value_t'($urandom()));
      idle_on = (phase != PHASES - 1) && (phase % 3 != 2);
      push_request(1'($urandom_range(0, 1)));
      run_draws(PHASE_ITEMS - 1);
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
